### rtl/assert_macros.svh
// Assertion macros used by the checker file of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every clock edge outside of reset.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property checked at every clock edge, during reset as well.
`define ASSERT_CLK_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/lcdr_pkg.sv
// Package with request codes, register offsets, reset values and screen constants.
package lcdr_pkg;

    // Request codes carried by req_type; the fourth code is unused.
    typedef enum logic [1:0] {
        REQ_READ  = 2'd0,
        REQ_WRITE = 2'd1,
        REQ_TICK  = 2'd2
    } t_req;

    // Register offsets from the base of the register window.
    typedef enum logic [3:0] {
        OFS_CTRL = 4'd0,
        OFS_STAT = 4'd1,
        OFS_SCY  = 4'd2,
        OFS_SCX  = 4'd3,
        OFS_LY   = 4'd4,
        OFS_LYC  = 4'd5,
        OFS_DMA  = 4'd6,
        OFS_BGP  = 4'd7,
        OFS_OBP0 = 4'd8,
        OFS_OBP1 = 4'd9,
        OFS_WY   = 4'd10,
        OFS_WX   = 4'd11
    } t_reg_ofs;

    // The window starts at 0xFF40; the upper twelve address bits select it.
    localparam logic [11:0] REG_PAGE  = 12'hFF4;
    localparam logic [3:0]  REG_COUNT = 4'd12;

    localparam logic [7:0] CTRL_RESET = 8'h91;
    localparam logic [7:0] STAT_RESET = 8'h80;
    localparam logic [7:0] BGP_RESET  = 8'hFC;
    localparam logic [7:0] OBP_RESET  = 8'hFF;
    localparam logic [7:0] UNMAPPED   = 8'hFF;

    localparam int WIN_ENABLE_BIT  = 5;
    localparam int COINCIDENCE_BIT = 2;
    localparam int LYC_IRQ_BIT     = 6;
    localparam int STAT_READ_BIT   = 7;

    localparam int SCREEN_HEIGHT = 144;
    localparam int SCREEN_WIDTH  = 160;

endpackage

### rtl/lcdr_if.sv
// Valid/ready channel interfaces for requests and results of the register block.
interface lcdr_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  req_type;
    logic [15:0] bus_addr;
    logic [7:0]  write_byte;

    modport source (output valid, output req_type, output bus_addr, output write_byte,
                    input ready);
    modport sink   (input valid, input req_type, input bus_addr, input write_byte,
                    output ready);
endinterface

interface lcdr_rsp_if;
    logic       valid;
    logic       ready;
    logic [7:0] read_byte;
    logic       stat_irq;
    logic       dma_start;
    logic [7:0] dma_page_out;
    logic [7:0] window_line;

    modport source (output valid, output read_byte, output stat_irq, output dma_start,
                    output dma_page_out, output window_line, input ready);
    modport sink   (input valid, input read_byte, input stat_irq, input dma_start,
                    input dma_page_out, input window_line, output ready);
endinterface

### rtl/lcd_registers_with_line_compare.sv
// Display controller register file with line counter and line-compare interrupt.
//
// This block holds the display controller registers at 0xFF40 to 0xFF4B and
// handles three kinds of request: bus reads, bus writes and end-of-line ticks.
// Every accepted request yields exactly one result transfer, in order. A request
// is captured in an input register; short decode and compare logic then reads
// and updates the register state and loads the result register, and one
// request can be accepted in every cycle while the block does not stall. The
// result register is the only buffer on the output side: while a finished
// result waits to be taken, the block still accepts a new request into its
// input register, and it stalls only when both registers are full.
// Reads of the status register always show bit 7 set; unmapped reads return
// 0xFF, and writes to the line counter or to unmapped addresses are dropped.
// A write to the DMA register raises dma_start for that result together with
// the new page on dma_page_out. On a tick, the window line counter advances if
// the window is enabled, placed on screen and covers the current line; then the
// line counter advances modulo 256 and the coincidence bit of the status
// register follows the comparison with line compare. A match with status bit 6
// set raises stat_irq. read_byte is zero for everything but a read, and the
// unused request code changes nothing.
module lcd_registers_with_line_compare (
    input  logic              i_clk,
    input  logic              i_rst_n,
    lcdr_req_if.sink          i_req,
    lcdr_rsp_if.source        o_rsp
);

    // Input register.
    logic        r_in_vld;
    logic [1:0]  r_in_type;
    logic [15:0] r_in_addr;
    logic [7:0]  r_in_data;

    // Architectural registers.
    logic [7:0] r_ctrl, n_ctrl;
    logic [7:0] r_stat, n_stat;
    logic [7:0] r_scy,  n_scy;
    logic [7:0] r_scx,  n_scx;
    logic [7:0] r_ly,   n_ly;
    logic [7:0] r_lyc,  n_lyc;
    logic [7:0] r_bgp,  n_bgp;
    logic [7:0] r_obp0, n_obp0;
    logic [7:0] r_obp1, n_obp1;
    logic [7:0] r_wy,   n_wy;
    logic [7:0] r_wx,   n_wx;
    logic [7:0] r_dma,  n_dma;
    logic [7:0] r_wline, n_wline;

    // Result register.
    logic       r_out_vld;
    logic [7:0] r_rd;
    logic       r_irq;
    logic       r_dma_go;
    logic [7:0] r_page;
    logic [7:0] r_wl;

    logic       adv;
    logic       mapped;
    logic [3:0] ofs;
    logic [7:0] n_rd;
    logic       n_irq;
    logic       n_dma_go;
    logic       win_vis;
    logic       win_cover;

    // The request in the input register moves on when the result register is
    // free or is being emptied in this cycle.
    assign adv         = r_in_vld && (!r_out_vld || o_rsp.ready);
    assign i_req.ready = !r_in_vld || adv;

    assign mapped = (r_in_addr[15:4] == lcdr_pkg::REG_PAGE) &&
                    (r_in_addr[3:0] < lcdr_pkg::REG_COUNT);
    assign ofs    = r_in_addr[3:0];

    // Window placement: enabled, left edge on screen, top edge on screen, and
    // the current line falls inside the window's height (compared without wrap).
    assign win_vis = r_ctrl[lcdr_pkg::WIN_ENABLE_BIT] &&
                     ({1'b0, r_wx} < 9'(lcdr_pkg::SCREEN_WIDTH + 7)) &&
                     ({1'b0, r_wy} < 9'(lcdr_pkg::SCREEN_HEIGHT));
    assign win_cover = (r_wy <= r_ly) &&
                       ({1'b0, r_ly} < ({1'b0, r_wy} + 9'(lcdr_pkg::SCREEN_HEIGHT)));

    always_comb begin
        n_ctrl   = r_ctrl;
        n_stat   = r_stat;
        n_scy    = r_scy;
        n_scx    = r_scx;
        n_ly     = r_ly;
        n_lyc    = r_lyc;
        n_bgp    = r_bgp;
        n_obp0   = r_obp0;
        n_obp1   = r_obp1;
        n_wy     = r_wy;
        n_wx     = r_wx;
        n_dma    = r_dma;
        n_wline  = r_wline;
        n_rd     = 8'h00;
        n_irq    = 1'b0;
        n_dma_go = 1'b0;
        case (r_in_type)
            lcdr_pkg::REQ_READ: begin
                if (!mapped) begin
                    n_rd = lcdr_pkg::UNMAPPED;
                end else begin
                    unique case (ofs)
                        lcdr_pkg::OFS_CTRL: n_rd = r_ctrl;
                        lcdr_pkg::OFS_STAT: n_rd = r_stat | 8'(1 << lcdr_pkg::STAT_READ_BIT);
                        lcdr_pkg::OFS_SCY:  n_rd = r_scy;
                        lcdr_pkg::OFS_SCX:  n_rd = r_scx;
                        lcdr_pkg::OFS_LY:   n_rd = r_ly;
                        lcdr_pkg::OFS_LYC:  n_rd = r_lyc;
                        lcdr_pkg::OFS_DMA:  n_rd = r_dma;
                        lcdr_pkg::OFS_BGP:  n_rd = r_bgp;
                        lcdr_pkg::OFS_OBP0: n_rd = r_obp0;
                        lcdr_pkg::OFS_OBP1: n_rd = r_obp1;
                        lcdr_pkg::OFS_WY:   n_rd = r_wy;
                        default:            n_rd = r_wx;
                    endcase
                end
            end
            lcdr_pkg::REQ_WRITE: begin
                if (mapped) begin
                    unique case (ofs)
                        lcdr_pkg::OFS_CTRL: n_ctrl = r_in_data;
                        lcdr_pkg::OFS_STAT: n_stat = r_in_data;
                        lcdr_pkg::OFS_SCY:  n_scy  = r_in_data;
                        lcdr_pkg::OFS_SCX:  n_scx  = r_in_data;
                        lcdr_pkg::OFS_LY:   n_ly   = r_ly;
                        lcdr_pkg::OFS_LYC:  n_lyc  = r_in_data;
                        lcdr_pkg::OFS_DMA: begin
                            n_dma    = r_in_data;
                            n_dma_go = 1'b1;
                        end
                        lcdr_pkg::OFS_BGP:  n_bgp  = r_in_data;
                        lcdr_pkg::OFS_OBP0: n_obp0 = r_in_data;
                        lcdr_pkg::OFS_OBP1: n_obp1 = r_in_data;
                        lcdr_pkg::OFS_WY:   n_wy   = r_in_data;
                        default:            n_wx   = r_in_data;
                    endcase
                end
            end
            lcdr_pkg::REQ_TICK: begin
                if (win_vis && win_cover) begin
                    n_wline = r_wline + 8'd1;
                end
                n_ly = r_ly + 8'd1;
                // The coincidence bit tracks the freshly advanced line counter.
                if (n_ly == r_lyc) begin
                    n_stat[lcdr_pkg::COINCIDENCE_BIT] = 1'b1;
                    n_irq = r_stat[lcdr_pkg::LYC_IRQ_BIT];
                end else begin
                    n_stat[lcdr_pkg::COINCIDENCE_BIT] = 1'b0;
                end
            end
            default: begin
                n_rd = 8'h00;
            end
        endcase
    end

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (i_req.ready) begin
            r_in_vld <= i_req.valid;
        end
        if (i_req.valid && i_req.ready) begin
            r_in_type <= i_req.req_type;
            r_in_addr <= i_req.bus_addr;
            r_in_data <= i_req.write_byte;
        end
    end

    // Register state is committed when the request moves into the result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctrl  <= lcdr_pkg::CTRL_RESET;
            r_stat  <= lcdr_pkg::STAT_RESET;
            r_scy   <= 8'h00;
            r_scx   <= 8'h00;
            r_ly    <= 8'h00;
            r_lyc   <= 8'h00;
            r_bgp   <= lcdr_pkg::BGP_RESET;
            r_obp0  <= lcdr_pkg::OBP_RESET;
            r_obp1  <= lcdr_pkg::OBP_RESET;
            r_wy    <= 8'h00;
            r_wx    <= 8'h00;
            r_dma   <= 8'h00;
            r_wline <= 8'h00;
        end else if (adv) begin
            r_ctrl  <= n_ctrl;
            r_stat  <= n_stat;
            r_scy   <= n_scy;
            r_scx   <= n_scx;
            r_ly    <= n_ly;
            r_lyc   <= n_lyc;
            r_bgp   <= n_bgp;
            r_obp0  <= n_obp0;
            r_obp1  <= n_obp1;
            r_wy    <= n_wy;
            r_wx    <= n_wx;
            r_dma   <= n_dma;
            r_wline <= n_wline;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (adv) begin
            r_out_vld <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_vld <= 1'b0;
        end
        if (adv) begin
            r_rd     <= n_rd;
            r_irq    <= n_irq;
            r_dma_go <= n_dma_go;
            r_page   <= n_dma;
            r_wl     <= n_wline;
        end
    end

    assign o_rsp.valid        = r_out_vld;
    assign o_rsp.read_byte    = r_rd;
    assign o_rsp.stat_irq     = r_irq;
    assign o_rsp.dma_start    = r_dma_go;
    assign o_rsp.dma_page_out = r_page;
    assign o_rsp.window_line  = r_wl;

endmodule

### rtl/lcdr_checker.sv
// Port-level checker for the register block, attached to the register block by bind.
`include "assert_macros.svh"

module lcdr_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_rsp_valid,
    input logic       i_rsp_ready,
    input logic [7:0] i_rsp_read_byte,
    input logic       i_rsp_stat_irq,
    input logic       i_rsp_dma_start,
    input logic [7:0] i_rsp_dma_page,
    input logic [7:0] i_rsp_window_line
);

    // An interrupt comes only from a tick and a DMA start only from a write.
    `ASSERT_CLK(a_strobes_exclusive, i_clk, i_rst_n, i_rsp_valid |-> !(i_rsp_stat_irq && i_rsp_dma_start), "stat_irq and dma_start in one result")

    // Read data is nonzero only for reads, which raise no strobe.
    `ASSERT_CLK(a_strobe_no_data, i_clk, i_rst_n, (i_rsp_valid && (i_rsp_stat_irq || i_rsp_dma_start)) |-> (i_rsp_read_byte == 8'h00), "read data on a strobe result")

    // A stalled result holds until it is taken.
    `ASSERT_CLK(a_stall_hold, i_clk, i_rst_n, (i_rsp_valid && !i_rsp_ready) |=> (i_rsp_valid && $stable(i_rsp_read_byte) && $stable(i_rsp_stat_irq) && $stable(i_rsp_dma_start) && $stable(i_rsp_dma_page) && $stable(i_rsp_window_line)), "stalled result changed")

    // Reset empties the result register.
    `ASSERT_CLK_ALWAYS(a_reset_empty, i_clk, !i_rst_n |=> !i_rsp_valid, "result valid after reset")

endmodule

bind lcd_registers_with_line_compare lcdr_checker u_lcdr_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_rsp_valid       (o_rsp.valid),
    .i_rsp_ready       (o_rsp.ready),
    .i_rsp_read_byte   (o_rsp.read_byte),
    .i_rsp_stat_irq    (o_rsp.stat_irq),
    .i_rsp_dma_start   (o_rsp.dma_start),
    .i_rsp_dma_page    (o_rsp.dma_page_out),
    .i_rsp_window_line (o_rsp.window_line)
);

### tb/lcdr_shadow_regs.sv
// Shadow model and result check for the display register block, fed by channel monitoring.
module lcdr_shadow_regs
    import lcdr_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    lcdr_req_if  i_req,
    lcdr_rsp_if  i_rsp,
    output int   o_errors,
    output int   o_pending
);

    typedef struct packed {
        logic [7:0] read_byte;
        logic       stat_irq;
        logic       dma_start;
        logic [7:0] dma_page_out;
        logic [7:0] window_line;
    } t_lcd_result;

    logic [7:0] sh_ctrl, sh_stat, sh_scy, sh_scx, sh_ly, sh_lyc;
    logic [7:0] sh_bgp, sh_obp0, sh_obp1, sh_wy, sh_wx, sh_dma, sh_win_line;

    t_lcd_result awaited_results[$];

    initial o_errors = 0;
    initial o_pending = 0;

    task automatic report_mismatch(input string msg);
        $display("%0t lcdr_shadow_regs: %s", $time, msg);
        o_errors = o_errors + 1;
    endtask

    // Applies one request to the shadow registers and returns the result it must produce.
    function automatic t_lcd_result apply_request(input logic [1:0] kind,
                                                  input logic [15:0] addr,
                                                  input logic [7:0] data);
        t_lcd_result res;
        t_reg_ofs    ofs;
        logic        mapped;
        logic        win_on;
        res = '0;
        ofs = t_reg_ofs'(addr[3:0]);
        mapped = (addr[15:4] == REG_PAGE) && (addr[3:0] < REG_COUNT);
        case (kind)
            REQ_READ: begin
                if (!mapped) begin
                    res.read_byte = UNMAPPED;
                end else begin
                    case (ofs)
                        OFS_CTRL: res.read_byte = sh_ctrl;
                        OFS_STAT: res.read_byte = sh_stat | (8'h01 << STAT_READ_BIT);
                        OFS_SCY:  res.read_byte = sh_scy;
                        OFS_SCX:  res.read_byte = sh_scx;
                        OFS_LY:   res.read_byte = sh_ly;
                        OFS_LYC:  res.read_byte = sh_lyc;
                        OFS_DMA:  res.read_byte = sh_dma;
                        OFS_BGP:  res.read_byte = sh_bgp;
                        OFS_OBP0: res.read_byte = sh_obp0;
                        OFS_OBP1: res.read_byte = sh_obp1;
                        OFS_WY:   res.read_byte = sh_wy;
                        default:  res.read_byte = sh_wx;
                    endcase
                end
            end
            REQ_WRITE: begin
                if (mapped) begin
                    case (ofs)
                        OFS_CTRL: sh_ctrl = data;
                        OFS_STAT: sh_stat = data;
                        OFS_SCY:  sh_scy = data;
                        OFS_SCX:  sh_scx = data;
                        OFS_LY:   ;
                        OFS_LYC:  sh_lyc = data;
                        OFS_DMA: begin
                            sh_dma = data;
                            res.dma_start = 1'b1;
                        end
                        OFS_BGP:  sh_bgp = data;
                        OFS_OBP0: sh_obp0 = data;
                        OFS_OBP1: sh_obp1 = data;
                        OFS_WY:   sh_wy = data;
                        default:  sh_wx = data;
                    endcase
                end
            end
            REQ_TICK: begin
                win_on = sh_ctrl[WIN_ENABLE_BIT] && (int'(sh_wx) < SCREEN_WIDTH + 7)
                         && (int'(sh_wy) < SCREEN_HEIGHT);
                // The window range is taken without wrap, so a low window near the
                // bottom simply runs off the end of the line counter.
                if (win_on && sh_wy <= sh_ly && int'(sh_ly) < int'(sh_wy) + SCREEN_HEIGHT)
                    sh_win_line = sh_win_line + 8'd1;
                sh_ly = sh_ly + 8'd1;
                if (sh_ly == sh_lyc) begin
                    sh_stat[COINCIDENCE_BIT] = 1'b1;
                    res.stat_irq = sh_stat[LYC_IRQ_BIT];
                end else begin
                    sh_stat[COINCIDENCE_BIT] = 1'b0;
                end
            end
            default: ;
        endcase
        res.dma_page_out = sh_dma;
        res.window_line = sh_win_line;
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_lcd_result want;
        if (!i_rst_n) begin
            sh_ctrl = CTRL_RESET;
            sh_stat = STAT_RESET;
            sh_scy = '0;
            sh_scx = '0;
            sh_ly = '0;
            sh_lyc = '0;
            sh_bgp = BGP_RESET;
            sh_obp0 = OBP_RESET;
            sh_obp1 = OBP_RESET;
            sh_wy = '0;
            sh_wx = '0;
            sh_dma = '0;
            sh_win_line = '0;
            awaited_results.delete();
        end else begin
            // Results are taken before requests so a transfer never meets its own prediction.
            if (i_rsp.valid === 1'b1 && i_rsp.ready === 1'b1) begin
                if (awaited_results.size() == 0) begin
                    report_mismatch("result transfer with nothing outstanding");
                end else begin
                    want = awaited_results.pop_front();
                    if (i_rsp.read_byte !== want.read_byte)
                        report_mismatch($sformatf("read_byte want %02h got %02h",
                                                  want.read_byte, i_rsp.read_byte));
                    if (i_rsp.stat_irq !== want.stat_irq)
                        report_mismatch($sformatf("stat_irq want %b got %b",
                                                  want.stat_irq, i_rsp.stat_irq));
                    if (i_rsp.dma_start !== want.dma_start)
                        report_mismatch($sformatf("dma_start want %b got %b",
                                                  want.dma_start, i_rsp.dma_start));
                    if (i_rsp.dma_page_out !== want.dma_page_out)
                        report_mismatch($sformatf("dma_page_out want %02h got %02h",
                                                  want.dma_page_out, i_rsp.dma_page_out));
                    if (i_rsp.window_line !== want.window_line)
                        report_mismatch($sformatf("window_line want %02h got %02h",
                                                  want.window_line, i_rsp.window_line));
                end
            end
            if (i_req.valid === 1'b1 && i_req.ready === 1'b1)
                awaited_results.push_back(apply_request(i_req.req_type, i_req.bus_addr,
                                                        i_req.write_byte));
        end
        o_pending <= awaited_results.size();
    end

endmodule

### tb/tb_top.sv
// Top of the register block testbench: clock, reset, request stimulus, result stalls, verdict.
module tb_top;
    import lcdr_pkg::*;

    // The fourth request code has no name in the package; the block must treat it as a no-op.
    localparam logic [1:0] REQ_UNUSED = 2'd3;

    // Number of random requests sent after the directed part.
    localparam int RANDOM_ITEMS = 1425;

    // Receiver behavior, picked anew at random whenever the current mode runs out.
    typedef enum logic [1:0] {
        RDY_FULL,
        RDY_ALTERNATE,
        RDY_RANDOM,
        RDY_SPARSE
    } t_rdy_mode;

    logic i_clk = 1'b0;
    logic i_rst_n;

    lcdr_req_if req_ch();
    lcdr_rsp_if rsp_ch();

    int errors;
    int pending;

    // Sender burst state and a running copy of the line counter, which is only
    // used to aim line compare writes at lines that are about to come.
    int          burst_left = 1;
    logic [7:0]  lines_ticked = '0;

    int unsigned stall_left = 0;
    t_rdy_mode   stall_mode = RDY_FULL;

    always #6 i_clk = ~i_clk;

    lcd_registers_with_line_compare uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    lcdr_shadow_regs shadow (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (req_ch),
        .i_rsp     (rsp_ch),
        .o_errors  (errors),
        .o_pending (pending)
    );

    // The receiver runs its own stall pattern, independent of the sender. Each
    // mode lasts a random stretch: always ready, every other cycle, a random 60
    // percent, or one cycle in sixteen so the result register fills and the
    // block has to push back on requests.
    always @(posedge i_clk) begin
        if (stall_left == 0) begin
            stall_mode <= t_rdy_mode'($urandom_range(0, 3));
            stall_left <= $urandom_range(10, 60);
        end else begin
            stall_left <= stall_left - 1;
        end
        case (stall_mode)
            RDY_FULL:      rsp_ch.ready <= 1'b1;
            RDY_ALTERNATE: rsp_ch.ready <= stall_left[0];
            RDY_RANDOM:    rsp_ch.ready <= ($urandom_range(0, 9) < 6);
            default:       rsp_ch.ready <= (stall_left[3:0] == 4'd0);
        endcase
    end

    function automatic logic [15:0] reg_addr(input t_reg_ofs ofs);
        return {REG_PAGE, ofs};
    endfunction

    // Presents one request and holds it until the block takes it. Valid stays
    // high across a burst; at the end of a burst it drops for a random gap,
    // though some bursts run straight into the next one with no gap at all.
    task automatic send_req(input logic [1:0] kind, input logic [15:0] addr,
                            input logic [7:0] data);
        int unsigned gap;
        req_ch.valid      <= 1'b1;
        req_ch.req_type   <= kind;
        req_ch.bus_addr   <= addr;
        req_ch.write_byte <= data;
        @(posedge i_clk);
        while (req_ch.ready !== 1'b1)
            @(posedge i_clk);
        if (kind == REQ_TICK)
            lines_ticked = lines_ticked + 8'd1;
        burst_left = burst_left - 1;
        if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 9);
            if (gap > 0) begin
                req_ch.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    initial begin
        int unsigned sent;
        int unsigned sel;
        int unsigned drain;
        logic [1:0]  kind;
        logic [15:0] addr;
        logic [7:0]  data;

        req_ch.valid      = 1'b0;
        req_ch.req_type   = REQ_READ;
        req_ch.bus_addr   = '0;
        req_ch.write_byte = '0;
        rsp_ch.ready      = 1'b0;
        i_rst_n           = 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part. Reset values first, including the status register with
        // its forced top bit, then every kind of unmapped address at and around
        // the register window.
        send_req(REQ_READ, reg_addr(OFS_CTRL), 8'h00);
        send_req(REQ_READ, reg_addr(OFS_STAT), 8'h00);
        send_req(REQ_READ, 16'hFF3F, 8'h00);
        send_req(REQ_READ, 16'hFF4C, 8'h00);
        send_req(REQ_READ, 16'hFFFF, 8'h00);
        send_req(REQ_READ, 16'h0000, 8'h00);
        // Enable the line compare interrupt, aim line compare at the next line and
        // tick once: the coincidence bit sets and the interrupt fires.
        send_req(REQ_WRITE, reg_addr(OFS_STAT), 8'h44);
        send_req(REQ_WRITE, reg_addr(OFS_LYC), 8'h01);
        send_req(REQ_TICK, 16'h0000, 8'h00);
        // The line counter ignores writes.
        send_req(REQ_WRITE, reg_addr(OFS_LY), 8'h55);
        send_req(REQ_READ, reg_addr(OFS_LY), 8'h00);
        // DMA strobes with both extreme pages.
        send_req(REQ_WRITE, reg_addr(OFS_DMA), 8'hFF);
        send_req(REQ_WRITE, reg_addr(OFS_DMA), 8'h00);
        // Window enabled at the largest position that is still on screen.
        send_req(REQ_WRITE, reg_addr(OFS_CTRL), 8'hFF);
        send_req(REQ_WRITE, reg_addr(OFS_WX), 8'hA6);
        send_req(REQ_WRITE, reg_addr(OFS_WY), 8'h8F);
        send_req(REQ_WRITE, 16'h1234, 8'hFF);
        // The unused request code must neither write nor strobe.
        send_req(REQ_UNUSED, reg_addr(OFS_DMA), 8'hAA);
        send_req(REQ_TICK, 16'hFFFF, 8'hFF);
        send_req(REQ_READ, reg_addr(OFS_STAT), 8'h00);
        send_req(REQ_WRITE, reg_addr(OFS_STAT), 8'h00);
        // One step past the right edge hides the window.
        send_req(REQ_WRITE, reg_addr(OFS_WX), 8'hA7);
        send_req(REQ_TICK, 16'h0000, 8'h00);
        send_req(REQ_READ, reg_addr(OFS_WX), 8'h00);
        send_req(REQ_READ, reg_addr(OFS_WY), 8'h00);

        // Random part. Most addresses land inside the register window, a few
        // just outside it, and the rest anywhere in the 16-bit space so every
        // address bit toggles. Ticks are frequent enough for the line counter
        // to wrap, and half of the line compare writes target a line a few ticks
        // ahead so coincidences and interrupts actually happen.
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            sel = $urandom_range(0, 99);
            if (sel < 33)
                kind = REQ_READ;
            else if (sel < 66)
                kind = REQ_WRITE;
            else if (sel < 95)
                kind = REQ_TICK;
            else
                kind = REQ_UNUSED;

            sel = $urandom_range(0, 9);
            if (sel < 7)
                addr = {REG_PAGE, 4'($urandom_range(0, REG_COUNT - 1))};
            else if (sel < 8)
                addr = $urandom_range(0, 1) ? 16'hFF3F
                                            : {REG_PAGE, 4'($urandom_range(REG_COUNT, 15))};
            else
                addr = 16'($urandom);

            data = 8'($urandom);
            if (kind == REQ_WRITE && addr == reg_addr(OFS_LYC) && $urandom_range(0, 1))
                data = lines_ticked + 8'($urandom_range(1, 6));

            sent = sent + 1;
            send_req(kind, addr, data);
        end
        req_ch.valid <= 1'b0;

        // Drain: wait for every outstanding result, bounded, then let the
        // two-stage pipeline run on to show any stray transfer.
        @(posedge i_clk);
        drain = 0;
        while (pending != 0 && drain < 5000) begin
            @(posedge i_clk);
            drain = drain + 1;
        end
        repeat (6) @(posedge i_clk);

        if (errors == 0 && pending == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

    // Safety net against a hung handshake; far beyond the slowest correct run.
    initial begin
        #6000000;
        $display("tb_top: errors");
        $finish;
    end

endmodule
